// ===== sv/imft_pkg.sv =====
// Shared types and constants of the IPv4 mask filter table.
`default_nettype none

package imft_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ActionW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_CHECK  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POST
  } state_e;

  // One table entry as it sits in the RAM word.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             reject;
    status_e          status;
    logic [SlotW-1:0] slot;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/imft_req_if.sv =====
// Request channel interface of the IPv4 mask filter table.
`default_nettype none

interface imft_req_if;
  logic                          valid;
  logic                          ready;
  logic [imft_pkg::ActionW-1:0]  action;
  logic [imft_pkg::AddrW-1:0]    address;
  logic [imft_pkg::AddrW-1:0]    filter_mask;
  logic [imft_pkg::AddrW-1:0]    filter_value;

  modport source (output valid, action, address, filter_mask, filter_value, input ready);
  modport sink   (input valid, action, address, filter_mask, filter_value, output ready);
endinterface

`default_nettype wire

// ===== sv/imft_rsp_if.sv =====
// Response channel interface of the IPv4 mask filter table.
`default_nettype none

interface imft_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          reject;
  logic [imft_pkg::StatusW-1:0]  status;
  logic [imft_pkg::SlotW-1:0]    slot;

  modport source (output valid, reject, status, slot, input ready);
  modport sink   (input valid, reject, status, slot, output ready);
endinterface

`default_nettype wire

// ===== sv/imft_cfg_if.sv =====
// Configuration write channel interface of the IPv4 mask filter table.
`default_nettype none

interface imft_cfg_if;
  logic valid;
  logic ready;
  logic ban_mode;

  modport source (output valid, ban_mode, input ready);
  modport sink   (input valid, ban_mode, output ready);
endinterface

`default_nettype wire

// ===== sv/imft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ipv4_mask_filter_table_top.sv =====
// Top level of the IPv4 mask filter table: sequencer, shared compare unit and entry RAM.
`default_nettype none

// Channel   Dir  Payload                                        Transaction
// in_if     in   action, address, filter_mask, filter_value     valid && ready
// out_if    out  reject, status, slot                           valid && ready
// cfg_if    in   ban_mode                                       valid && ready (always ready)
//
// Every request except an unused action code walks the used part of the table up to the
// first hit, one entry read from the entry RAM per cycle; the single RAM read port and the
// one compare unit set that rate. An unused action code skips the scan and returns an
// all-zero result. Reset clears the fill count and the control state; no clearing pass is
// needed. A new request is taken once the previous result has moved into the output
// register, so a stalled output stalls at most one further request.

module ipv4_mask_filter_table_top #(
  parameter int unsigned TableDepth = 1024
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  imft_req_if.sink   in_if,
  imft_rsp_if.source out_if,
  imft_cfg_if.sink   cfg_if
);

  localparam int unsigned IdxW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW   = $clog2(TableDepth + 1);
  localparam int unsigned EntryW = $bits(imft_pkg::entry_t);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  // Sequencer state.
  imft_pkg::state_e state_q, state_d;

  // Request held for the whole scan.
  imft_pkg::action_e           op_q;
  logic [imft_pkg::AddrW-1:0]  addr_q;
  logic [imft_pkg::AddrW-1:0]  fmask_q;
  logic [imft_pkg::AddrW-1:0]  fval_q;

  // Scan pointer, read in flight, and the fill count. Entries at or above the fill
  // count were never written and are never read, so the RAM needs no clearing.
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] used_q, used_d;

  logic ban_q;

  imft_pkg::result_t res_q, res_d;
  imft_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Entry RAM signals.
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  imft_pkg::entry_t  ram_wentry;
  logic [EntryW-1:0] ram_rdata;
  imft_pkg::entry_t  rd_entry;

  logic in_acc;
  logic cmp_match;
  logic hit_now;
  logic more;
  logic post_free;

  logic [IdxW-1:0]         slot_src;
  logic [IdxW+imft_pkg::SlotW-1:0] slot_ext;

  assign in_acc    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == imft_pkg::S_IDLE);
  assign cfg_if.ready = 1'b1;

  imft_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = imft_pkg::entry_t'(ram_rdata);

  // The shared compare unit: what counts as a hit depends on the request.
  always_comb begin
    case (op_q)
      imft_pkg::ACT_CHECK:  cmp_match = rd_entry.valid &&
                                        ((addr_q & rd_entry.mask) == rd_entry.value);
      imft_pkg::ACT_ADD:    cmp_match = !rd_entry.valid;
      imft_pkg::ACT_REMOVE: cmp_match = rd_entry.valid && (rd_entry.mask == fmask_q) &&
                                        (rd_entry.value == fval_q);
      default:              cmp_match = 1'b0;
    endcase
  end

  assign hit_now   = pend_q && cmp_match;
  assign more      = (idx_q < used_q);
  assign post_free = !out_valid_q || out_if.ready;

  // Slot numbers keep only their low bits.
  assign slot_ext = {{imft_pkg::SlotW{1'b0}}, slot_src};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      imft_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_if.action == imft_pkg::ACT_CHECK || in_if.action == imft_pkg::ACT_ADD ||
              in_if.action == imft_pkg::ACT_REMOVE) begin
            state_d = imft_pkg::S_SCAN;
          end else begin
            state_d = imft_pkg::S_POST;
          end
        end
      end
      imft_pkg::S_SCAN: begin
        if (hit_now || !more) begin
          state_d = imft_pkg::S_POST;
        end
      end
      imft_pkg::S_POST: begin
        if (post_free) begin
          state_d = imft_pkg::S_IDLE;
        end
      end
      default: state_d = imft_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    idx_d       = idx_q;
    pend_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    used_d      = used_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;
    ram_we      = 1'b0;
    ram_waddr   = rd_idx_q;
    ram_wentry  = '{valid: 1'b1, mask: fmask_q, value: fval_q};
    slot_src    = rd_idx_q;

    case (state_q)
      imft_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          res_d = '0;
        end
      end
      imft_pkg::S_SCAN: begin
        if (hit_now) begin
          // First hit at the entry read last cycle.
          res_d.slot = slot_ext[imft_pkg::SlotW-1:0];
          case (op_q)
            imft_pkg::ACT_CHECK: begin
              res_d.reject = ban_q;
            end
            imft_pkg::ACT_ADD: begin
              ram_we = 1'b1;
            end
            imft_pkg::ACT_REMOVE: begin
              ram_we           = 1'b1;
              ram_wentry.valid = 1'b0;
            end
            default: ;
          endcase
        end else if (more) begin
          pend_d   = 1'b1;
          rd_idx_d = idx_q[IdxW-1:0];
          idx_d    = idx_q + 1'b1;
        end else begin
          // Whole used range scanned without a hit.
          case (op_q)
            imft_pkg::ACT_CHECK: begin
              res_d.reject = !ban_q;
            end
            imft_pkg::ACT_ADD: begin
              if (used_q < DepthCnt) begin
                slot_src   = used_q[IdxW-1:0];
                ram_we     = 1'b1;
                ram_waddr  = used_q[IdxW-1:0];
                used_d     = used_q + 1'b1;
                res_d.slot = slot_ext[imft_pkg::SlotW-1:0];
              end else begin
                res_d.status = imft_pkg::ST_FULL;
              end
            end
            imft_pkg::ACT_REMOVE: begin
              res_d.status = imft_pkg::ST_NOT_FOUND;
            end
            default: ;
          endcase
        end
      end
      imft_pkg::S_POST: begin
        if (post_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imft_pkg::S_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      ban_q       <= 1'b1;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_if.valid) begin
        ban_q <= cfg_if.ban_mode;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= imft_pkg::action_e'(in_if.action);
      addr_q  <= in_if.address;
      fmask_q <= in_if.filter_mask;
      fval_q  <= in_if.filter_value;
    end
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_if.valid  = out_valid_q;
  assign out_if.reject = out_q.reject;
  assign out_if.status = out_q.status;
  assign out_if.slot   = out_q.slot;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the IPv4 mask filter table: directed rows, then random traffic.
`timescale 1ns / 1ps

module testbench;

  // The block runs at its full table depth. Random traffic keeps the fill count well
  // below it, so most scans stay short.
  localparam int unsigned TableSlots = 1024;

  // The action field has one code that the block must treat as a no-op.
  localparam logic [imft_pkg::ActionW-1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned IdlePct    = 17;
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned ShowErrors = 10;

  typedef struct packed {
    logic [imft_pkg::ActionW-1:0] action;
    logic [imft_pkg::AddrW-1:0]   address;
    logic [imft_pkg::AddrW-1:0]   fmask;
    logic [imft_pkg::AddrW-1:0]   fvalue;
  } filter_req_t;

  // One row of the directed part. A row may be sent several times in a row, and the
  // expected verdict is typed in only where it is plain from the request alone.
  typedef struct {
    filter_req_t       req;
    int                reps;
    bit                typed;
    imft_pkg::result_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  imft_req_if req_if ();
  imft_rsp_if rsp_if ();
  imft_cfg_if cfg_if ();

  ipv4_mask_filter_table_top #(
    .TableDepth(TableSlots)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (req_if),
    .out_if(rsp_if),
    .cfg_if(cfg_if)
  );

  // Shadow copy of the filter table, the fill count and the ban mode register.
  logic [imft_pkg::AddrW-1:0] shadow_mask  [TableSlots];
  logic [imft_pkg::AddrW-1:0] shadow_value [TableSlots];
  bit                         shadow_valid [TableSlots];
  int unsigned                fill_count;
  bit                         ban_on;

  imft_pkg::result_t pending_verdicts[$];
  dir_row_t          dir_rows[$];
  int                error_cnt;
  bit                calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #10_000_000;
    $display("ipv4_mask_filter_table_top verification failed");
    $finish;
  end

  // The receiver stalls about one time in six, except during calm stretches.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Works out the verdict of one request and applies its effect to the shadow table.
  // Only entries below the fill count take part in any scan, so an entry that was never
  // written is never looked at.
  function automatic imft_pkg::result_t table_verdict(input filter_req_t rq);
    imft_pkg::result_t r;
    int unsigned       i;
    int unsigned       hit_at;
    bit                hit;

    r      = '0;
    r.status = imft_pkg::ST_DONE;
    hit    = 1'b0;
    hit_at = 0;
    case (rq.action)
      imft_pkg::ACT_CHECK: begin
        for (i = 0; i < fill_count && !hit; i++) begin
          if (shadow_valid[i] && ((rq.address & shadow_mask[i]) == shadow_value[i])) begin
            hit    = 1'b1;
            hit_at = i;
          end
        end
        // A match rejects in ban mode; with no match only allow mode rejects.
        r.reject = hit ? ban_on : !ban_on;
        r.slot   = hit ? imft_pkg::SlotW'(hit_at) : '0;
      end
      imft_pkg::ACT_ADD: begin
        // Reuse the lowest freed slot first, then append, else report a full table.
        for (i = 0; i < fill_count && !hit; i++) begin
          if (!shadow_valid[i]) begin
            hit    = 1'b1;
            hit_at = i;
          end
        end
        if (!hit && fill_count < TableSlots) begin
          hit        = 1'b1;
          hit_at     = fill_count;
          fill_count = fill_count + 1;
        end
        if (hit) begin
          shadow_mask[hit_at]  = rq.fmask;
          shadow_value[hit_at] = rq.fvalue;
          shadow_valid[hit_at] = 1'b1;
          r.slot               = imft_pkg::SlotW'(hit_at);
        end else begin
          r.status = imft_pkg::ST_FULL;
        end
      end
      imft_pkg::ACT_REMOVE: begin
        // Only an exact match of both mask and value frees an entry.
        for (i = 0; i < fill_count && !hit; i++) begin
          if (shadow_valid[i] && shadow_mask[i] == rq.fmask &&
              shadow_value[i] == rq.fvalue) begin
            hit    = 1'b1;
            hit_at = i;
          end
        end
        if (hit) begin
          shadow_valid[hit_at] = 1'b0;
          r.slot               = imft_pkg::SlotW'(hit_at);
        end else begin
          r.status = imft_pkg::ST_NOT_FOUND;
        end
      end
      default: ;  // The unused code changes nothing and returns an all-zero result.
    endcase
    return r;
  endfunction

  // Random request. Most are well formed: per-octet masks, values inside their mask,
  // checks aimed at live entries and removes naming live filters. The rest is noise.
  function automatic filter_req_t random_request();
    filter_req_t rq;
    int unsigned live[$];
    int unsigned pick;
    int unsigned roll;
    int unsigned k;

    for (k = 0; k < fill_count; k++) begin
      if (shadow_valid[k]) live.push_back(k);
    end
    rq.address = $urandom;
    for (k = 0; k < 4; k++) rq.fmask[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    rq.fvalue = $urandom & rq.fmask;
    pick      = (live.size() > 0) ? live[$urandom_range(live.size() - 1)] : 0;
    roll      = $urandom_range(99);
    if (roll < 4) begin
      rq.action = ACT_UNUSED;
      rq.fmask  = $urandom;
      rq.fvalue = $urandom;
    end else if (roll < 48) begin
      rq.action = imft_pkg::ACT_CHECK;
      if (live.size() > 0 && $urandom_range(99) < 60) begin
        rq.address = (shadow_value[pick] & shadow_mask[pick]) | ($urandom & ~shadow_mask[pick]);
      end
    end else if (roll < 74) begin
      rq.action = imft_pkg::ACT_ADD;
      if ($urandom_range(99) < 15) rq.fmask = $urandom;
      if ($urandom_range(99) < 10) rq.fvalue = $urandom;
    end else begin
      rq.action = imft_pkg::ACT_REMOVE;
      if (live.size() > 0 && $urandom_range(99) < 70) begin
        rq.fmask  = shadow_mask[pick];
        rq.fvalue = shadow_value[pick];
      end
    end
    return rq;
  endfunction

  task automatic flag_error(input string msg);
    error_cnt++;
    if (error_cnt <= ShowErrors) $display("%s", msg);
  endtask

  // Sends one request. The valid line is only lowered when an idle cycle is inserted,
  // so back-to-back transactions never see a low and a high in the same time step.
  task automatic issue_request(input filter_req_t rq, input bit typed,
                               input imft_pkg::result_t want);
    imft_pkg::result_t verdict;

    while (!calm && $urandom_range(99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= rq.action;
    req_if.address      <= rq.address;
    req_if.filter_mask  <= rq.fmask;
    req_if.filter_value <= rq.fvalue;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    verdict = table_verdict(rq);
    pending_verdicts.push_back(typed ? want : verdict);
  endtask

  // Holds the sender back until every outstanding verdict has been returned.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_ban_mode(input bit mode);
    drain_results();
    cfg_if.valid    <= 1'b1;
    cfg_if.ban_mode <= mode;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    ban_on = mode;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic add_row(input logic [imft_pkg::ActionW-1:0] action,
                         input logic [imft_pkg::AddrW-1:0] address,
                         input logic [imft_pkg::AddrW-1:0] fmask,
                         input logic [imft_pkg::AddrW-1:0] fvalue,
                         input int reps, input bit typed, input logic reject,
                         input imft_pkg::status_e status,
                         input logic [imft_pkg::SlotW-1:0] slot);
    dir_row_t row;

    row.req         = '{action, address, fmask, fvalue};
    row.reps        = reps;
    row.typed       = typed;
    row.want.reject = reject;
    row.want.status = status;
    row.want.slot   = slot;
    dir_rows.push_back(row);
  endtask

  // Every returned transaction is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin : verdict_check
    imft_pkg::result_t want;

    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("unexpected result: reject %0d status %0d slot %0d",
                             rsp_if.reject, rsp_if.status, rsp_if.slot));
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_if.reject !== want.reject || rsp_if.status !== want.status ||
            rsp_if.slot !== want.slot) begin
          flag_error($sformatf(
              "mismatch: expected reject %0d status %0d slot %0d, got %0d %0d %0d",
              want.reject, want.status, want.slot,
              rsp_if.reject, rsp_if.status, rsp_if.slot));
        end
      end
    end
  end

  initial begin : stimulus
    filter_req_t rq;
    int          p;
    int          n;
    int          r;

    // Every input is at a known level from time zero on.
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.action       <= imft_pkg::ACT_CHECK;
    req_if.address      <= '0;
    req_if.filter_mask  <= '0;
    req_if.filter_value <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.ban_mode     <= 1'b1;
    calm                 = 1'b0;
    error_cnt            = 0;
    fill_count           = 0;
    ban_on               = 1'b1;
    for (p = 0; p < TableSlots; p++) begin
      shadow_mask[p]  = '0;
      shadow_value[p] = '0;
      shadow_valid[p] = 1'b0;
    end

    // Directed rows, run with ban mode at its reset value. The empty table rejects
    // nothing in ban mode, and a remove on it finds nothing.
    add_row(imft_pkg::ACT_CHECK, 32'h0, 32'h0, 32'h0, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_REMOVE, 32'h0, 32'h0000_00FF, 32'h0000_000A, 1, 1'b1, 1'b0,
            imft_pkg::ST_NOT_FOUND, 10'd0);
    // The unused action code with every bit set must do nothing at all.
    add_row(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    // Three appends, among them an all-ones filter and one whose value lies outside its
    // mask, which is stored as given but can never match.
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'h0000_00FF, 32'h0000_000A, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd1);
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'h0000_FFFF, 32'h00FF_0000, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd2);
    add_row(imft_pkg::ACT_CHECK, 32'h0101_000A, 32'h0, 32'h0, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_CHECK, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_CHECK, 32'h00FF_0000, 32'h0, 32'h0, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    // A freed slot must stop matching, and a second remove of the same filter fails.
    add_row(imft_pkg::ACT_REMOVE, 32'h0, 32'h0000_00FF, 32'h0000_000A, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_CHECK, 32'h0000_000A, 32'h0, 32'h0, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_REMOVE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd1);
    add_row(imft_pkg::ACT_REMOVE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b0,
            imft_pkg::ST_NOT_FOUND, 10'd0);
    // An add goes to the lowest freed slot; the match-all filter then catches everything.
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'h0, 32'h0, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_CHECK, 32'h1234_5678, 32'h0, 32'h0, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    // A run of identical adds fills the freed slot and then appends.
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'hFF00_0000, 32'hC000_0000, 8, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'h0000_FF00, 32'h0000_AB00, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_REMOVE, 32'h0, 32'h0, 32'h0, 1, 1'b1, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_ADD, 32'h0, 32'hFFFF_FF00, 32'h00A8_C000, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);
    add_row(imft_pkg::ACT_CHECK, 32'hC000_00FF, 32'h0, 32'h0, 1, 1'b0, 1'b0,
            imft_pkg::ST_DONE, 10'd0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      for (r = 0; r < dir_rows[i].reps; r++) begin
        issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, with the ban mode register rewritten before each one while the
    // block is idle. Allow mode comes first so both settings see a well-filled table.
    for (p = 0; p < 4; p++) begin
      set_ban_mode(p[0] ? 1'b1 : 1'b0);
      for (n = 0; n < PhaseItems; n++) begin
        // The second phase opens with a long stretch where neither side idles.
        calm = (p == 1 && n < 100);
        // Midway through the third phase the sender waits for every result.
        if (p == 2 && n == PhaseItems / 2) drain_results();
        rq = random_request();
        issue_request(rq, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // Let the last results come back, then wait out a full table scan so that any
    // stray transaction shows.
    drain_results();
    repeat (TableSlots + 8) @(posedge clk_i);

    if (error_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("ipv4_mask_filter_table_top verification clean");
    end else begin
      $display("ipv4_mask_filter_table_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/imft_pkg.sv
sv/imft_req_if.sv
sv/imft_rsp_if.sv
sv/imft_cfg_if.sv
sv/imft_ram.sv
sv/ipv4_mask_filter_table_top.sv
tb/testbench.sv
